// ----- hw/rtl/sott_pkg.sv -----
`default_nettype none
package sott_pkg;

  localparam int MAX_SEGMENTS = 64;
  localparam int POS_W        = 31;
  localparam int CNT_W        = $clog2(MAX_SEGMENTS + 1);

  // opcodes
  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_APPEND = 2'd1;
  localparam logic [1:0] OP_U2S    = 2'd2;
  localparam logic [1:0] OP_S2U    = 2'd3;

  // status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_MISS     = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;

  typedef struct packed {
    logic [1:0]       opcode;
    logic [POS_W-1:0] position;
    logic [POS_W-1:0] seg_length;
  } cmd_t;

  typedef struct packed {
    logic [POS_W-1:0] mapped_position;
    logic [1:0]       status;
  } result_t;

  typedef struct packed {
    logic [POS_W-1:0] source_start;
    logic [POS_W-1:0] span;
    logic [POS_W-1:0] unrolled_start;
  } seg_t;

  // query item walking down the cell row
  typedef struct packed {
    logic             active;
    logic             u2s;
    logic [POS_W-1:0] q;
    logic             hit;
    logic [POS_W-1:0] mapped;
  } token_t;

endpackage
`default_nettype wire

// ----- hw/rtl/sott_cell.sv -----
`default_nettype none
module sott_cell import sott_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             wr_en,
  input  wire seg_t             wr_seg,
  input  wire logic             valid,
  input  wire logic             nxt_valid,
  input  wire logic [POS_W-1:0] nxt_unrolled,
  input  wire token_t           tok_in,
  output token_t                tok_out,
  output logic [POS_W-1:0]      unrolled
);

  seg_t             seg;
  token_t           tok_next;
  logic             match;
  logic [POS_W:0]   span_end;
  logic [POS_W-1:0] add_term;
  logic [POS_W-1:0] sub_term;
  logic [POS_W:0]   sum;

  assign unrolled = seg.unrolled_start;
  assign span_end = {1'b0, seg.source_start} + {1'b0, seg.span};

  always_comb begin
    if (tok_in.u2s) begin
      match = valid && (tok_in.q >= seg.unrolled_start) &&
              (!nxt_valid || (tok_in.q < nxt_unrolled));
    end else begin
      match = valid && (tok_in.q >= seg.source_start) &&
              ({1'b0, tok_in.q} < span_end);
    end
  end

  // q + a - b, with q >= b whenever match holds
  assign add_term = tok_in.u2s ? seg.source_start : seg.unrolled_start;
  assign sub_term = tok_in.u2s ? seg.unrolled_start : seg.source_start;
  assign sum      = {1'b0, tok_in.q} + {1'b0, add_term} - {1'b0, sub_term};

  always_comb begin
    tok_next = tok_in;
    if (tok_in.active && !tok_in.hit && match) begin
      tok_next.hit    = 1'b1;
      tok_next.mapped = sum[POS_W] ? {POS_W{1'b1}} : sum[POS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      seg <= wr_seg;
    end
  end

  // only the active flag needs a reset, the rest follows it
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.active <= 1'b0;
    end else begin
      tok_out.active <= tok_next.active;
    end
    tok_out.u2s    <= tok_next.u2s;
    tok_out.q      <= tok_next.q;
    tok_out.hit    <= tok_next.hit;
    tok_out.mapped <= tok_next.mapped;
  end

endmodule
`default_nettype wire

// ----- hw/rtl/segment_offset_translation_table_core.sv -----
`default_nettype none
// segment offset translation table: a row of MAX_SEGMENTS cells, each holding one
// segment (source start, length, unrolled start). clear and append take effect at
// once and give their result in the cycle after start; busy stays low. a translation
// query walks the cell row one cell per cycle, so its result comes out once it has
// passed every cell whatever the fill level, and busy is high until the done strobe.
// done is high for exactly one cycle with the result on result; the receiver cannot
// stall it, so the result must be taken in that cycle. new items are taken only while
// busy is low.
module segment_offset_translation_table_core import sott_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    start,
  input  wire cmd_t    cmd,
  output logic         busy,
  output logic         done,
  output result_t      result
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_WALK = 2'b10
  } state_t;

  state_t           state;
  logic [CNT_W-1:0] count;
  logic [POS_W-1:0] total;

  logic             accept;
  logic             is_query;
  logic [POS_W:0]   total_sum;
  logic             app_reject;
  seg_t             new_seg;

  // chain wiring: tok[i] feeds cell i, tok[MAX_SEGMENTS] leaves the row
  token_t           tok      [MAX_SEGMENTS+1];
  logic             valid    [MAX_SEGMENTS+1];
  logic [POS_W-1:0] unrolled [MAX_SEGMENTS+1];

  assign busy     = (state == ST_WALK);
  assign accept   = start && !busy;
  assign is_query = cmd.opcode[1];

  // running sum check for append
  assign total_sum  = {1'b0, total} + {1'b0, cmd.seg_length};
  assign app_reject = (count == CNT_W'(MAX_SEGMENTS)) || total_sum[POS_W];

  assign new_seg.source_start   = cmd.position;
  assign new_seg.span           = cmd.seg_length;
  assign new_seg.unrolled_start = total;

  // query enters cell 0 in the cycle it is accepted
  assign tok[0].active = accept && is_query;
  assign tok[0].u2s    = (cmd.opcode == OP_U2S);
  assign tok[0].q      = cmd.position;
  assign tok[0].hit    = 1'b0;
  assign tok[0].mapped = '0;

  // past the last cell there is no neighbor
  assign valid[MAX_SEGMENTS]    = 1'b0;
  assign unrolled[MAX_SEGMENTS] = '0;

  for (genvar i = 0; i < MAX_SEGMENTS; i++) begin : g_cell
    logic wr_en;
    // a cell holds a segment only below the fill count
    assign valid[i] = (CNT_W'(i) < count);
    assign wr_en    = accept && (cmd.opcode == OP_APPEND) && !app_reject &&
                      (count == CNT_W'(i));

    sott_cell u_cell (
      .clk          (clk),
      .rst          (rst),
      .wr_en        (wr_en),
      .wr_seg       (new_seg),
      .valid        (valid[i]),
      .nxt_valid    (valid[i+1]),
      .nxt_unrolled (unrolled[i+1]),
      .tok_in       (tok[i]),
      .tok_out      (tok[i+1]),
      .unrolled     (unrolled[i])
    );
  end

  // control: fill count, running total, walk tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
      total <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            unique case (cmd.opcode) inside
              OP_CLEAR: begin
                count <= '0;
                total <= '0;
                done  <= 1'b1;
              end
              OP_APPEND: begin
                if (!app_reject) begin
                  count <= count + CNT_W'(1);
                  total <= total_sum[POS_W-1:0];
                end
                done <= 1'b1;
              end
              OP_U2S, OP_S2U: begin
                state <= ST_WALK;
              end
              default: begin
                state <= ST_IDLE;
              end
            endcase
          end
        end
        ST_WALK: begin
          // query has passed every cell
          if (tok[MAX_SEGMENTS].active) begin
            done  <= 1'b1;
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && accept && !is_query) begin
      result.mapped_position <= '0;
      if (cmd.opcode == OP_APPEND && app_reject) begin
        result.status <= ST_OVERFLOW;
      end else begin
        result.status <= ST_OK;
      end
    end else if (state == ST_WALK && tok[MAX_SEGMENTS].active) begin
      if (tok[MAX_SEGMENTS].hit) begin
        result.mapped_position <= tok[MAX_SEGMENTS].mapped;
        result.status          <= ST_OK;
      end else begin
        result.mapped_position <= '0;
        result.status          <= ST_MISS;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("done while busy");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_SEGMENTS))
    else $error("fill count beyond table size");

  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    (accept && is_query) |=> busy)
    else $error("query accepted without walk");

  a_edit_done: assert property (@(posedge clk) disable iff (rst)
    (accept && !is_query) |=> (done && !busy))
    else $error("clear or append gave no result");

  a_tail_in_walk: assert property (@(posedge clk) disable iff (rst)
    tok[MAX_SEGMENTS].active |-> (state == ST_WALK))
    else $error("query left the row outside a walk");
`endif

endmodule
`default_nettype wire

// ----- dv/tb_segment_offset_translation_table_core.sv -----
`timescale 1ns / 1ps
// self-checking bench for the segment offset translation table
// - one sender task drives items through the start/busy handshake
// - a mirror of the segment table predicts each result at the accepting edge
// - one checker process compares every done strobe with the oldest prediction
module tb_segment_offset_translation_table_core;
  import sott_pkg::*;

  // the last segment is open-ended, so one all-ones query reaches the top of the range
  localparam logic [POS_W-1:0] POS_MAX = '1;
  // generous bound: every item a full-row query plus the longest sender gap
  localparam int CYCLE_LIMIT = 400000;
  // a query walks the whole cell row before done
  localparam int DRAIN_CYCLES = MAX_SEGMENTS + 8;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    start = 1'b0;
  cmd_t    cmd = '0;
  logic    busy;
  logic    done;
  result_t result;

  // mirror of the segment table, written only on accepted appends
  logic [POS_W-1:0] tbl_source   [MAX_SEGMENTS] = '{default: '0};
  logic [POS_W-1:0] tbl_span     [MAX_SEGMENTS] = '{default: '0};
  logic [POS_W-1:0] tbl_unrolled [MAX_SEGMENTS] = '{default: '0};
  int               tbl_count = 0;
  logic [POS_W-1:0] tbl_total = '0;

  result_t expected_results[$];
  int      error_count = 0;
  int      cycle_count = 0;
  // chance in percent that the sender holds start low in a given cycle
  int      idle_pct = 0;

  always #1 clk = ~clk;

  segment_offset_translation_table_core i_dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done),
    .result (result)
  );

  // apply one accepted item to the mirror table and return its result
  function automatic result_t predict_result(cmd_t c);
    result_t          r;
    logic [POS_W:0]   sum;
    logic [POS_W:0]   upper;
    logic             found;
    int               i;
    r = '0;
    r.status = ST_OK;
    found = 1'b0;
    case (c.opcode)
      OP_CLEAR: begin
        tbl_count = 0;
        tbl_total = '0;
      end
      OP_APPEND: begin
        // reject on a full table or when the running sum leaves 31 bits
        sum = {1'b0, tbl_total} + {1'b0, c.seg_length};
        if (tbl_count >= MAX_SEGMENTS || sum[POS_W]) begin
          r.status = ST_OVERFLOW;
        end else begin
          tbl_source[tbl_count]   = c.position;
          tbl_span[tbl_count]     = c.seg_length;
          tbl_unrolled[tbl_count] = tbl_total;
          tbl_total = sum[POS_W-1:0];
          tbl_count++;
        end
      end
      OP_U2S: begin
        // first segment whose unrolled range holds the query, last one open-ended
        for (i = 0; i < tbl_count && !found; i++) begin
          if (c.position >= tbl_unrolled[i] &&
              (i == tbl_count - 1 || c.position < tbl_unrolled[i+1])) begin
            sum = {1'b0, c.position - tbl_unrolled[i]} + {1'b0, tbl_source[i]};
            r.mapped_position = sum[POS_W] ? POS_MAX : sum[POS_W-1:0];
            found = 1'b1;
          end
        end
        if (!found) r.status = ST_MISS;
      end
      default: begin
        // first segment whose source range holds the query, bound taken without wrap
        for (i = 0; i < tbl_count && !found; i++) begin
          upper = {1'b0, tbl_source[i]} + {1'b0, tbl_span[i]};
          if (c.position >= tbl_source[i] && {1'b0, c.position} < upper) begin
            sum = {1'b0, tbl_unrolled[i]} + {1'b0, c.position - tbl_source[i]};
            r.mapped_position = sum[POS_W] ? POS_MAX : sum[POS_W-1:0];
            found = 1'b1;
          end
        end
        if (!found) r.status = ST_MISS;
      end
    endcase
    return r;
  endfunction

  // drive one item, optionally after idle cycles, and wait for the accepting edge
  task automatic send_item(input logic [1:0] op, input logic [POS_W-1:0] pos,
                           input logic [POS_W-1:0] len);
    cmd_t c;
    c.opcode     = op;
    c.position   = pos;
    c.seg_length = len;
    // each cycle the sender may stay idle
    while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    cmd   <= c;
    do @(posedge clk); while (busy);
    expected_results.push_back(predict_result(c));
  endtask

  // hold off the sender until every outstanding result is back
  task automatic drain_results();
    start <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  // both translations miss while nothing is stored
  task automatic test_empty_table();
    send_item(OP_CLEAR, '0, '0);
    send_item(OP_U2S, '0, POS_MAX);
    send_item(OP_S2U, '0, POS_MAX);
    send_item(OP_U2S, POS_MAX, '0);
    send_item(OP_S2U, POS_MAX, '0);
  endtask

  // hits, misses at range edges, and a zero-length segment in the middle
  task automatic test_segment_mapping();
    send_item(OP_APPEND, 31'd1000, 31'd100);
    send_item(OP_APPEND, 31'd50, 31'd0);
    send_item(OP_APPEND, 31'd50, 31'd200);
    send_item(OP_U2S, 31'd0, '0);
    send_item(OP_U2S, 31'd99, '0);
    // zero-length segment shares its start with the next one and is shadowed
    send_item(OP_U2S, 31'd100, '0);
    send_item(OP_U2S, 31'd5000, '0);
    send_item(OP_S2U, 31'd1099, '0);
    send_item(OP_S2U, 31'd1100, '0);
    send_item(OP_S2U, 31'd50, '0);
    send_item(OP_S2U, 31'd49, '0);
  endtask

  // source start near the top so a deep query into the last segment saturates
  task automatic test_saturation();
    send_item(OP_CLEAR, POS_MAX, POS_MAX);
    send_item(OP_APPEND, POS_MAX - 31'd10, 31'd5);
    send_item(OP_U2S, 31'd3, '0);
    send_item(OP_U2S, POS_MAX, '0);
    // zero-length segment as the last one is still open-ended
    send_item(OP_APPEND, 31'd7, 31'd0);
    send_item(OP_U2S, 31'd5, '0);
    send_item(OP_S2U, 31'd7, '0);
  endtask

  // running sum must stay within 31 bits, landing exactly on the top is fine
  task automatic test_sum_overflow();
    send_item(OP_CLEAR, '0, '0);
    send_item(OP_APPEND, 31'd0, 31'd10);
    send_item(OP_APPEND, 31'd5, POS_MAX);
    send_item(OP_APPEND, 31'd3, POS_MAX - 31'd10);
    send_item(OP_APPEND, 31'd0, 31'd1);
    send_item(OP_APPEND, 31'd9, 31'd0);
    send_item(OP_U2S, POS_MAX, '0);
    send_item(OP_S2U, POS_MAX - 31'd11, '0);
  endtask

  // fill every cell, then one more append must bounce
  task automatic test_full_table();
    int i;
    send_item(OP_CLEAR, '0, '0);
    for (i = 0; i < MAX_SEGMENTS; i++) begin
      send_item(OP_APPEND, 31'($urandom_range(0, 3000)), 31'($urandom_range(0, 40)));
    end
    send_item(OP_APPEND, 31'd1, 31'd1);
    send_item(OP_U2S, tbl_unrolled[MAX_SEGMENTS-1], '0);
    send_item(OP_U2S, 31'($urandom_range(0, tbl_total + 20)), '0);
    send_item(OP_S2U, tbl_source[MAX_SEGMENTS-1], '0);
  endtask

  // sessions of clear, appends and queries with random content, plus some noise
  task automatic test_random_traffic(input int item_count);
    int               sent;
    int               seg_cnt;
    int               j;
    logic [POS_W-1:0] p;
    logic [POS_W-1:0] l;
    sent = 0;
    while (sent < item_count) begin
      if ($urandom_range(99) < 85) begin
        send_item(OP_CLEAR, 31'($urandom), 31'($urandom));
        sent++;
        case ($urandom_range(9))
          0:       seg_cnt = $urandom_range(40, 70);
          1:       seg_cnt = $urandom_range(0, 1);
          default: seg_cnt = $urandom_range(1, 8);
        endcase
        repeat (seg_cnt) begin
          case ($urandom_range(9))
            0:       p = 31'($urandom);
            1:       p = 31'(POS_MAX - $urandom_range(0, 1000));
            default: p = 31'($urandom_range(0, 20000));
          endcase
          case ($urandom_range(19))
            0:       l = 31'($urandom);
            1, 2:    l = '0;
            // aim at the top of the running sum, on either side of it
            3:       l = POS_MAX - tbl_total + 31'($urandom_range(0, 2)) - 31'd1;
            4, 5:    l = 31'($urandom_range(1, 1048576));
            default: l = 31'($urandom_range(1, 500));
          endcase
          send_item(OP_APPEND, p, l);
          sent++;
        end
        repeat ($urandom_range(1, 6)) begin
          j = (tbl_count > 0) ? $urandom_range(0, tbl_count - 1) : 0;
          if ($urandom_range(1) == 1) begin
            case ($urandom_range(5))
              0:       p = 31'($urandom);
              1:       p = tbl_unrolled[j];
              2:       p = tbl_unrolled[j] - 31'd1;
              default: p = 31'($urandom_range(0, tbl_total + 50));
            endcase
            send_item(OP_U2S, p, 31'($urandom));
          end else begin
            case ($urandom_range(5))
              0:       p = 31'($urandom);
              1:       p = tbl_source[j] - 31'd1;
              2:       p = tbl_source[j] + tbl_span[j];
              default: p = tbl_source[j] +
                           31'($urandom_range(0, (tbl_span[j] != 0) ? tbl_span[j] - 1 : 0));
            endcase
            send_item(OP_S2U, p, 31'($urandom));
          end
          sent++;
        end
      end else begin
        // noise: any opcode with any field bits
        send_item(2'($urandom), 31'($urandom), 31'($urandom));
        sent++;
      end
    end
  endtask

  // checker: each done strobe against the oldest prediction
  always @(posedge clk) begin : check_results
    result_t want;
    if (!rst && done) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result, mapped_position %h status %h", $time,
                 result.mapped_position, result.status);
        error_count++;
      end else begin
        want = expected_results.pop_front();
        if (result.mapped_position !== want.mapped_position) begin
          $display("%0t: mapped_position mismatch, expected %h actual %h", $time,
                   want.mapped_position, result.mapped_position);
          error_count++;
        end
        if (result.status !== want.status) begin
          $display("%0t: status mismatch, expected %h actual %h", $time,
                   want.status, result.status);
          error_count++;
        end
      end
    end
  end

  // watchdog on a cycle count
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb: failure");
    $finish;
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed part, no sender gaps
    test_empty_table();
    test_segment_mapping();
    test_saturation();
    test_sum_overflow();
    test_full_table();
    drain_results();

    // random part: sender idles rarely, then often, then never
    idle_pct = 28;
    test_random_traffic(290);
    drain_results();
    idle_pct = 69;
    test_random_traffic(290);
    drain_results();
    idle_pct = 0;
    test_random_traffic(270);

    // let the last query finish its walk and catch any stray strobe
    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
